FILE: hw/rtl/lltc_pkg.sv
// ---------------------------------------------------------------------------
// lltc_pkg: shared types and constants of the cache table
// mode codes, result codes, table geometry and the front-to-back queue item
// ---------------------------------------------------------------------------
package lltc_pkg;

   localparam int ENTRIES        = 16;
   localparam int IDX_W          = $clog2(ENTRIES);
   localparam int HW_W           = $clog2(ENTRIES + 1);
   localparam int OVERHEAD_BYTES = 12;
   localparam int TOTAL_W        = 21;
   localparam int SIZE_W         = 17;
   localparam int CFG_RESET      = 16384;
   localparam int MS_PER_SEC     = 1000;
   localparam int PCT_DEFAULT    = 80;
   localparam int PCT_MAX        = 100;
   localparam int PCT_MIN        = 10;
   // floor(x / 100) as (x * RECIP_100) >> RECIP_SHIFT, exact for x below 2^32
   localparam int RECIP_100      = 1374389535;
   localparam int RECIP_SHIFT    = 37;

   typedef enum logic [2:0] {
      MODE_PUT     = 3'd0,
      MODE_GET     = 3'd1,
      MODE_HAS     = 3'd2,
      MODE_REMOVE  = 3'd3,
      MODE_CLEAR   = 3'd4,
      MODE_CLEANUP = 3'd5,
      MODE_OPT     = 3'd6,
      MODE_BAD     = 3'd7
   } mode_type;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_REJ  = 2'd2;

   // classified item passed from front to back
   typedef struct packed {
      mode_type            mode;
      logic [31:0]         tag;
      logic [SIZE_W-1:0]   size;
      logic                size_zero;
      logic [22:0]         ttl;
      logic [31:0]         now;
      logic [28:0]         scaled;     // budget times target percent
   } work_type;

endpackage

FILE: hw/rtl/lltc_front.sv
// ---------------------------------------------------------------------------
// lltc_front: input stage of the cache table
// accepts requests, computes entry size and scaled optimize budget, queues work
// ---------------------------------------------------------------------------
module lltc_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [135:0]                req_tdata,
   input  logic [lltc_pkg::TOTAL_W-1:0] cap,
   output logic                        q_valid,
   input  logic                        q_pop,
   output lltc_pkg::work_type          q_item
);
   // two-entry queue
   lltc_pkg::work_type q_ff [2];
   lltc_pkg::work_type q_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic [2:0]  f_mode;
   logic [7:0]  f_kb, f_tb, f_pct, pct;
   logic [15:0] f_cb;
   logic [28:0] prod;
   logic        push;

   assign f_mode = req_tdata[2:0];
   assign f_kb   = req_tdata[42:35];
   assign f_cb   = req_tdata[58:43];
   assign f_tb   = req_tdata[66:59];
   assign f_pct  = req_tdata[129:122];
   assign pct    = (f_pct < 8'(lltc_pkg::PCT_MIN) || f_pct > 8'(lltc_pkg::PCT_MAX))
                   ? 8'(lltc_pkg::PCT_DEFAULT) : f_pct;
   assign prod   = 29'(cap) * 29'(pct);

   always_comb begin
      q_in.mode      = lltc_pkg::mode_type'(f_mode);
      q_in.tag       = req_tdata[34:3];
      q_in.size      = lltc_pkg::SIZE_W'(f_kb) + lltc_pkg::SIZE_W'(f_cb)
                     + lltc_pkg::SIZE_W'(f_tb) + lltc_pkg::SIZE_W'(lltc_pkg::OVERHEAD_BYTES);
      q_in.size_zero = (f_kb == 8'd0) || (f_cb == 16'd0);
      q_in.ttl       = req_tdata[89:67];
      q_in.now       = req_tdata[121:90];
      q_in.scaled    = prod;
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (cnt_ff != 2'd0);
   assign q_item     = q_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + 2'(push) - 2'(q_pop);
      rd_in  = rd_ff ^ q_pop;
      wr_in  = wr_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
      end
      if (push) q_ff[wr_ff] <= q_in;
   end

   property p_no_overflow;
      @(posedge clock) disable iff (reset) cnt_ff <= 2'd2;
   endproperty
   a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("pop of empty queue");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !req_tready) else $error("ready while full");
endmodule

FILE: hw/rtl/lltc_back.sv
// ---------------------------------------------------------------------------
// lltc_back: execution engine of the cache table
// sequencer that scans slots one per cycle and updates the table
// ---------------------------------------------------------------------------
module lltc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_valid,
   output logic                         q_pop,
   input  lltc_pkg::work_type           q_item,
   input  logic [lltc_pkg::TOTAL_W-1:0] cap,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [95:0]                  rsp_tdata
);
   localparam int IW = lltc_pkg::IDX_W;
   localparam int HW = lltc_pkg::HW_W;
   localparam int TW = lltc_pkg::TOTAL_W;
   localparam int SW = lltc_pkg::SIZE_W;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_LOOK   = 10'b0000000010,
      S_FREE   = 10'b0000000100,
      S_VICT   = 10'b0000001000,
      S_EVICT  = 10'b0000010000,
      S_SWEEP  = 10'b0000100000,
      S_WRITE  = 10'b0001000000,
      S_HIT    = 10'b0010000000,
      S_CLEAR  = 10'b0100000000,
      S_DONE   = 10'b1000000000
   } state_type;

   state_type st_ff;

   logic              v_ff [lltc_pkg::ENTRIES];
   logic [31:0]       tag_ff [lltc_pkg::ENTRIES];
   logic [SW-1:0]     size_ff [lltc_pkg::ENTRIES];
   logic [31:0]       touch_ff [lltc_pkg::ENTRIES];
   logic [22:0]       ttl_ff [lltc_pkg::ENTRIES];
   logic [31:0]       uses_ff [lltc_pkg::ENTRIES];

   lltc_pkg::work_type w_ff;
   logic [HW-1:0] hwm_ff;
   logic [TW-1:0] tot_ff;
   logic [31:0]   hits_ff, miss_ff;
   logic [HW-1:0] i_ff;          // scan index
   logic          found_ff;      // scan result present
   logic [IW-1:0] best_ff;       // scan result slot
   logic [31:0]   bu_ff, bt_ff;  // best uses and touch
   logic [IW-1:0] dst_ff;        // target slot of a put
   logic          vphase_ff;     // victim scan for budget, not for a slot
   logic          expired_ff;    // expiry of the slot under scan
   logic [TW-1:0] tgt_ff;        // optimize target in bytes
   logic [1:0]    status_ff;
   logic [IW-1:0] slot_ff;
   logic [4:0]    rem_ff;
   logic          ov_ff;
   logic [95:0]   od_ff;

   logic [IW-1:0] ci;
   logic          exp_c;
   logic [31:0]   age;
   logic [31:0]   lim;
   logic          over;
   logic          in_hw;
   logic [59:0]   tprod;

   assign ci    = i_ff[IW-1:0];
   assign in_hw = (i_ff < hwm_ff);
   assign age   = w_ff.now - touch_ff[ci];
   assign lim   = 32'(ttl_ff[ci]) * 32'(lltc_pkg::MS_PER_SEC);
   assign exp_c = (ttl_ff[ci] != 23'd0) && (age >= lim);
   assign over  = (22'(tot_ff) + 22'(w_ff.size)) > 22'(cap);
   // divide by 100 through reciprocal multiply, registered during the sweep
   assign tprod = 60'(w_ff.scaled) * 60'(lltc_pkg::RECIP_100);

   assign q_pop      = (st_ff == S_IDLE) && q_valid;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         hwm_ff  <= '0;
         tot_ff  <= '0;
         hits_ff <= '0;
         miss_ff <= '0;
         ov_ff   <= 1'b0;
         for (int k = 0; k < lltc_pkg::ENTRIES; k++) begin
            v_ff[k]     <= 1'b0;
            tag_ff[k]   <= '0;
            size_ff[k]  <= '0;
            touch_ff[k] <= '0;
            ttl_ff[k]   <= '0;
            uses_ff[k]  <= '0;
         end
      end else begin
         if (ov_ff && rsp_tready) ov_ff <= 1'b0;
         unique case (st_ff)
            S_IDLE: begin
               if (q_pop) begin
                  w_ff      <= q_item;
                  i_ff      <= '0;
                  found_ff  <= 1'b0;
                  status_ff <= lltc_pkg::ST_OK;
                  slot_ff   <= '0;
                  rem_ff    <= '0;
                  unique case (q_item.mode)
                     lltc_pkg::MODE_PUT: begin
                        if (q_item.size_zero) begin
                           status_ff <= lltc_pkg::ST_REJ;
                           st_ff     <= S_DONE;
                        end else st_ff <= S_LOOK;
                     end
                     lltc_pkg::MODE_GET, lltc_pkg::MODE_HAS,
                     lltc_pkg::MODE_REMOVE: st_ff <= S_LOOK;
                     lltc_pkg::MODE_CLEAR:  st_ff <= S_CLEAR;
                     lltc_pkg::MODE_CLEANUP,
                     lltc_pkg::MODE_OPT:    st_ff <= S_SWEEP;
                     default: begin
                        status_ff <= lltc_pkg::ST_REJ;
                        st_ff     <= S_DONE;
                     end
                  endcase
               end
            end
            S_LOOK: begin
               // linear tag search below the high-water mark
               if (in_hw && v_ff[ci] && tag_ff[ci] == w_ff.tag) begin
                  best_ff    <= ci;
                  expired_ff <= exp_c;
                  st_ff      <= S_HIT;
               end else if (!in_hw || i_ff == HW'(lltc_pkg::ENTRIES - 1)) begin
                  // miss
                  case (w_ff.mode)
                     lltc_pkg::MODE_PUT: begin
                        if (22'(w_ff.size) > 22'(cap)) begin
                           status_ff <= lltc_pkg::ST_REJ;
                           st_ff     <= S_DONE;
                        end else begin
                           i_ff  <= '0;
                           st_ff <= S_FREE;
                        end
                     end
                     lltc_pkg::MODE_GET: begin
                        status_ff <= lltc_pkg::ST_MISS;
                        miss_ff   <= miss_ff + 32'd1;
                        st_ff     <= S_DONE;
                     end
                     default: begin
                        status_ff <= lltc_pkg::ST_MISS;
                        st_ff     <= S_DONE;
                     end
                  endcase
               end else i_ff <= i_ff + HW'(1);
            end
            S_HIT: begin
               case (w_ff.mode)
                  lltc_pkg::MODE_PUT: begin
                     tot_ff             <= tot_ff - TW'(size_ff[best_ff]) + TW'(w_ff.size);
                     size_ff[best_ff]   <= w_ff.size;
                     ttl_ff[best_ff]    <= w_ff.ttl;
                     uses_ff[best_ff]   <= uses_ff[best_ff] + 32'd1;
                     touch_ff[best_ff]  <= w_ff.now;
                     slot_ff            <= best_ff;
                  end
                  lltc_pkg::MODE_REMOVE: begin
                     tot_ff           <= tot_ff - TW'(size_ff[best_ff]);
                     v_ff[best_ff]    <= 1'b0;
                     tag_ff[best_ff]  <= '0;
                     size_ff[best_ff] <= '0;
                     touch_ff[best_ff] <= '0;
                     ttl_ff[best_ff]  <= '0;
                     uses_ff[best_ff] <= '0;
                     slot_ff          <= best_ff;
                  end
                  default: begin
                     if (expired_ff) begin
                        tot_ff            <= tot_ff - TW'(size_ff[best_ff]);
                        v_ff[best_ff]     <= 1'b0;
                        tag_ff[best_ff]   <= '0;
                        size_ff[best_ff]  <= '0;
                        touch_ff[best_ff] <= '0;
                        ttl_ff[best_ff]   <= '0;
                        uses_ff[best_ff]  <= '0;
                        status_ff         <= lltc_pkg::ST_MISS;
                        if (w_ff.mode == lltc_pkg::MODE_GET) miss_ff <= miss_ff + 32'd1;
                     end else begin
                        slot_ff <= best_ff;
                        if (w_ff.mode == lltc_pkg::MODE_GET) begin
                           hits_ff           <= hits_ff + 32'd1;
                           uses_ff[best_ff]  <= uses_ff[best_ff] + 32'd1;
                           touch_ff[best_ff] <= w_ff.now;
                        end
                     end
                  end
               endcase
               st_ff <= S_DONE;
            end
            S_FREE: begin
               // lowest free slot over the whole table
               if (!v_ff[ci]) begin
                  dst_ff    <= ci;
                  i_ff      <= '0;
                  found_ff  <= 1'b0;
                  vphase_ff <= 1'b1;
                  st_ff     <= over ? S_VICT : S_WRITE;
               end else if (i_ff == HW'(lltc_pkg::ENTRIES - 1)) begin
                  vphase_ff <= 1'b0;
                  i_ff      <= '0;
                  found_ff  <= 1'b0;
                  st_ff     <= S_VICT;
               end else i_ff <= i_ff + HW'(1);
            end
            S_VICT: begin
               // lowest use count, oldest touch breaks ties
               if (in_hw && v_ff[ci] && (!found_ff || uses_ff[ci] < bu_ff ||
                   (uses_ff[ci] == bu_ff && touch_ff[ci] < bt_ff))) begin
                  found_ff <= 1'b1;
                  best_ff  <= ci;
                  bu_ff    <= uses_ff[ci];
                  bt_ff    <= touch_ff[ci];
               end
               if (!in_hw || i_ff == HW'(lltc_pkg::ENTRIES - 1)) st_ff <= S_EVICT;
               else i_ff <= i_ff + HW'(1);
            end
            S_EVICT: begin
               // commits the scan result, or ends the operation
               if (w_ff.mode == lltc_pkg::MODE_PUT &&
                   (!found_ff || (vphase_ff && best_ff == dst_ff))) begin
                  status_ff <= lltc_pkg::ST_REJ;
                  st_ff     <= S_DONE;
               end else if (!found_ff) begin
                  st_ff <= S_DONE;
               end else begin
                  tot_ff            <= tot_ff - TW'(size_ff[best_ff]);
                  v_ff[best_ff]     <= 1'b0;
                  tag_ff[best_ff]   <= '0;
                  size_ff[best_ff]  <= '0;
                  touch_ff[best_ff] <= '0;
                  ttl_ff[best_ff]   <= '0;
                  uses_ff[best_ff]  <= '0;
                  i_ff              <= '0;
                  found_ff          <= 1'b0;
                  if (w_ff.mode == lltc_pkg::MODE_PUT) begin
                     if (!vphase_ff) begin
                        dst_ff    <= best_ff;
                        vphase_ff <= 1'b1;
                     end
                     st_ff <= S_WRITE;   // recheck budget there
                  end else begin
                     rem_ff <= rem_ff + 5'd1;
                     st_ff  <= S_WRITE;  // optimize recheck
                  end
               end
            end
            S_WRITE: begin
               if (w_ff.mode == lltc_pkg::MODE_PUT) begin
                  if (over) st_ff <= S_VICT;
                  else begin
                     v_ff[dst_ff]     <= 1'b1;
                     tag_ff[dst_ff]   <= w_ff.tag;
                     size_ff[dst_ff]  <= w_ff.size;
                     touch_ff[dst_ff] <= w_ff.now;
                     ttl_ff[dst_ff]   <= w_ff.ttl;
                     uses_ff[dst_ff]  <= '0;
                     tot_ff           <= tot_ff + TW'(w_ff.size);
                     if (HW'(dst_ff) >= hwm_ff) hwm_ff <= HW'(dst_ff) + HW'(1);
                     slot_ff <= dst_ff;
                     st_ff   <= S_DONE;
                  end
               end else begin
                  if (tot_ff > tgt_ff && hwm_ff != '0) st_ff <= S_VICT;
                  else st_ff <= S_DONE;
               end
            end
            S_SWEEP: begin
               tgt_ff <= tprod[lltc_pkg::RECIP_SHIFT +: TW];
               if (in_hw && v_ff[ci] && exp_c) begin
                  tot_ff        <= tot_ff - TW'(size_ff[ci]);
                  v_ff[ci]      <= 1'b0;
                  tag_ff[ci]    <= '0;
                  size_ff[ci]   <= '0;
                  touch_ff[ci]  <= '0;
                  ttl_ff[ci]    <= '0;
                  uses_ff[ci]   <= '0;
                  rem_ff        <= rem_ff + 5'd1;
               end
               if (!in_hw || i_ff == HW'(lltc_pkg::ENTRIES - 1)) begin
                  i_ff     <= '0;
                  found_ff <= 1'b0;
                  st_ff    <= (w_ff.mode == lltc_pkg::MODE_OPT) ? S_WRITE : S_DONE;
               end else i_ff <= i_ff + HW'(1);
            end
            S_CLEAR: begin
               for (int k = 0; k < lltc_pkg::ENTRIES; k++) begin
                  v_ff[k]     <= 1'b0;
                  tag_ff[k]   <= '0;
                  size_ff[k]  <= '0;
                  touch_ff[k] <= '0;
                  ttl_ff[k]   <= '0;
                  uses_ff[k]  <= '0;
               end
               hwm_ff <= '0;
               tot_ff <= '0;
               st_ff  <= S_DONE;
            end
            S_DONE: begin
               if (!ov_ff) begin
                  ov_ff <= 1'b1;
                  od_ff <= {tot_ff, miss_ff, hits_ff, rem_ff, 4'(slot_ff), status_ff};
                  st_ff <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   a_one_hot: assert property (@(posedge clock) disable iff (reset) $onehot(st_ff))
      else $error("state not one-hot");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> st_ff != S_IDLE) else $error("pop without start");
   a_hwm: assert property (@(posedge clock) disable iff (reset)
      hwm_ff <= HW'(lltc_pkg::ENTRIES)) else $error("high water out of range");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("response dropped");
endmodule

FILE: hw/rtl/lfu_lru_ttl_cache_table_top.sv
// ---------------------------------------------------------------------------
// lfu_lru_ttl_cache_table_top: lfu cache table with lru tie-break and ttl
// sixteen-slot table under a byte budget, with an apb-style budget register
// ---------------------------------------------------------------------------
// a rejected empty put or unknown mode goes straight to the response, clear wipes
//   the table in one state, and lookup, free-slot and sweep scan slot by slot; each
//   eviction adds one victim scan
// throughput: one transaction at a time in the back engine, set by its
//   one-slot-per-cycle scan; the front queues two more transactions
// reset: synchronous, clears the table, counters and queue; budget 16384
module lfu_lru_ttl_cache_table_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mode, key_tag, key_bytes, content_bytes, type_bytes, ttl_seconds,
   // now_ms, target_percent (from bit 0 up)
   input  logic [135:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status, slot_index, removed_count, hit_total, miss_total, used_bytes
   output logic [95:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [1:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   logic [lltc_pkg::TOTAL_W-1:0] cap_ff;
   logic                         q_valid, q_pop;
   lltc_pkg::work_type           q_item;

   // budget register at address zero
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? 32'(cap_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) cap_ff <= lltc_pkg::TOTAL_W'(lltc_pkg::CFG_RESET);
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0)
         cap_ff <= csr_pwdata[lltc_pkg::TOTAL_W-1:0];
   end

   lltc_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .cap(cap_ff), .q_valid, .q_pop, .q_item
   );

   lltc_back u_back (
      .clock, .reset, .q_valid, .q_pop, .q_item, .cap(cap_ff),
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );
endmodule

FILE: dv/lfu_lru_ttl_cache_table_checker.sv
// ---------------------------------------------------------------------------
// lfu_lru_ttl_cache_table_checker: result predictor and scoreboard
// watches the request, response and register ports of the cache table,
// keeps its own copy of the table and checks every response field by field
// ---------------------------------------------------------------------------
module lfu_lru_ttl_cache_table_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [135:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [95:0]  rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [1:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic         csr_pready,
   output int           fail_count,
   output int           pending,
   output int           items_seen,
   output int           hits_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] ADDR_CAPACITY = 2'd0;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  slot;
      logic [4:0]  removed;
      logic [31:0] hit_total;
      logic [31:0] miss_total;
      logic [20:0] used;
   } cache_result;

   cache_result expected_q[$];

   // shadow of the table
   logic [20:0] budget;
   bit          slot_vld   [lltc_pkg::ENTRIES];
   logic [31:0] slot_tag   [lltc_pkg::ENTRIES];
   logic [16:0] slot_size  [lltc_pkg::ENTRIES];
   logic [31:0] slot_touch [lltc_pkg::ENTRIES];
   logic [22:0] slot_ttl   [lltc_pkg::ENTRIES];
   logic [31:0] slot_uses  [lltc_pkg::ENTRIES];
   int          high_mark;
   logic [20:0] used_bytes;
   logic [31:0] hit_cnt, miss_cnt;

   function automatic void wipe_table();
      for (int i = 0; i < lltc_pkg::ENTRIES; i++) begin
         slot_vld[i] = 0; slot_tag[i] = '0; slot_size[i] = '0;
         slot_touch[i] = '0; slot_ttl[i] = '0; slot_uses[i] = '0;
      end
      high_mark = 0;
      used_bytes = '0;
   endfunction

   function automatic void drop_slot(int i);
      used_bytes = used_bytes - 21'(slot_size[i]);
      slot_vld[i] = 0; slot_tag[i] = '0; slot_size[i] = '0;
      slot_touch[i] = '0; slot_ttl[i] = '0; slot_uses[i] = '0;
   endfunction

   function automatic bit has_expired(int i, logic [31:0] now);
      logic [31:0] life;
      life = 32'(slot_ttl[i]) * 32'd1000;
      if (slot_ttl[i] == '0) return 0;
      return (now - slot_touch[i]) >= life;
   endfunction

   function automatic int find_tag(logic [31:0] tag);
      for (int i = 0; i < high_mark && i < lltc_pkg::ENTRIES; i++)
         if (slot_vld[i] && slot_tag[i] == tag) return i;
      return -1;
   endfunction

   // lowest use count, oldest touch breaks ties
   function automatic int coldest_slot();
      int best;
      best = -1;
      for (int i = 0; i < high_mark && i < lltc_pkg::ENTRIES; i++) begin
         if (!slot_vld[i]) continue;
         if (best < 0 || slot_uses[i] < slot_uses[best] ||
             (slot_uses[i] == slot_uses[best] && slot_touch[i] < slot_touch[best]))
            best = i;
      end
      return best;
   endfunction

   function automatic int sweep_stale(logic [31:0] now);
      int n;
      n = 0;
      for (int i = 0; i < high_mark && i < lltc_pkg::ENTRIES; i++)
         if (slot_vld[i] && has_expired(i, now)) begin
            drop_slot(i);
            n++;
         end
      return n;
   endfunction

   function automatic cache_result apply_op(logic [135:0] d);
      lltc_pkg::mode_type op;
      logic [31:0]  tag, now;
      logic [7:0]   kb, tb, pct;
      logic [15:0]  cb;
      logic [22:0]  ttl;
      logic [31:0]  need;
      longint       goal;
      int           idx, victim, pick;
      cache_result  r;
      op = lltc_pkg::mode_type'(d[2:0]);
      tag = d[34:3]; kb = d[42:35]; cb = d[58:43]; tb = d[66:59];
      ttl = d[89:67]; now = d[121:90]; pct = d[129:122];
      r.status = lltc_pkg::ST_OK; r.slot = '0; r.removed = '0;
      need = 32'(kb) + 32'(cb) + 32'(tb) + 32'(lltc_pkg::OVERHEAD_BYTES);
      case (op)
         lltc_pkg::MODE_PUT: begin
            if (kb == 0 || cb == 0) begin
               r.status = lltc_pkg::ST_REJ;
            end else begin
               idx = find_tag(tag);
               if (idx >= 0) begin
                  used_bytes = used_bytes - 21'(slot_size[idx]) + 21'(need);
                  slot_size[idx] = 17'(need);
                  slot_ttl[idx] = ttl;
                  slot_uses[idx]++;
                  slot_touch[idx] = now;
                  r.slot = 4'(idx);
               end else if (need > 32'(budget)) begin
                  r.status = lltc_pkg::ST_REJ;
               end else begin
                  pick = -1;
                  for (int i = lltc_pkg::ENTRIES - 1; i >= 0; i--)
                     if (!slot_vld[i]) pick = i;
                  if (pick < 0) begin
                     pick = coldest_slot();
                     if (pick < 0) r.status = lltc_pkg::ST_REJ;
                     else drop_slot(pick);
                  end
                  while (r.status == lltc_pkg::ST_OK &&
                         longint'(used_bytes) + need > longint'(budget)) begin
                     victim = coldest_slot();
                     if (victim < 0 || victim == pick) r.status = lltc_pkg::ST_REJ;
                     else drop_slot(victim);
                  end
                  if (r.status == lltc_pkg::ST_OK) begin
                     slot_vld[pick] = 1; slot_tag[pick] = tag;
                     slot_size[pick] = 17'(need); slot_touch[pick] = now;
                     slot_ttl[pick] = ttl; slot_uses[pick] = '0;
                     used_bytes = used_bytes + 21'(need);
                     if (pick >= high_mark) high_mark = pick + 1;
                     r.slot = 4'(pick);
                  end
               end
            end
         end
         lltc_pkg::MODE_GET, lltc_pkg::MODE_HAS: begin
            idx = find_tag(tag);
            if (idx < 0) begin
               r.status = lltc_pkg::ST_MISS;
            end else if (has_expired(idx, now)) begin
               drop_slot(idx);
               r.status = lltc_pkg::ST_MISS;
            end else begin
               r.slot = 4'(idx);
               if (op == lltc_pkg::MODE_GET) begin
                  slot_uses[idx]++;
                  slot_touch[idx] = now;
               end
            end
            if (op == lltc_pkg::MODE_GET) begin
               if (r.status == lltc_pkg::ST_OK) hit_cnt++;
               else miss_cnt++;
            end
         end
         lltc_pkg::MODE_REMOVE: begin
            idx = find_tag(tag);
            if (idx < 0) r.status = lltc_pkg::ST_MISS;
            else begin
               r.slot = 4'(idx);
               drop_slot(idx);
            end
         end
         lltc_pkg::MODE_CLEAR:   wipe_table();
         lltc_pkg::MODE_CLEANUP: r.removed = 5'(sweep_stale(now));
         lltc_pkg::MODE_OPT: begin
            if (pct < lltc_pkg::PCT_MIN || pct > lltc_pkg::PCT_MAX)
               pct = 8'(lltc_pkg::PCT_DEFAULT);
            goal = (longint'(budget) * longint'(pct)) / 100;
            r.removed = 5'(sweep_stale(now));
            while (longint'(used_bytes) > goal && high_mark > 0) begin
               victim = coldest_slot();
               if (victim < 0) break;
               drop_slot(victim);
               r.removed++;
            end
         end
         default: r.status = lltc_pkg::ST_REJ;
      endcase
      r.hit_total = hit_cnt;
      r.miss_total = miss_cnt;
      r.used = used_bytes;
      return r;
   endfunction

   always @(posedge clock) begin
      cache_result e, a;
      if (reset) begin
         budget = 21'(lltc_pkg::CFG_RESET);
         wipe_table();
         hit_cnt = '0;
         miss_cnt = '0;
         expected_q.delete();
         fail_count = 0;
         items_seen = 0;
         hits_seen = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == ADDR_CAPACITY)
            budget = csr_pwdata[20:0];
         // response transaction
         if (rsp_tvalid && rsp_tready) begin
            a.status = rsp_tdata[1:0];    a.slot = rsp_tdata[5:2];
            a.removed = rsp_tdata[10:6];  a.hit_total = rsp_tdata[42:11];
            a.miss_total = rsp_tdata[74:43]; a.used = rsp_tdata[95:75];
            if (expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("[%0t] unexpected response %h", $realtime, rsp_tdata);
            end else begin
               e = expected_q.pop_front();
               if (a !== e) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"[%0t] mismatch exp st=%0d slot=%0d rem=%0d hit=%0d miss=%0d",
                               " used=%0d | act st=%0d slot=%0d rem=%0d hit=%0d miss=%0d",
                               " used=%0d"}, $realtime,
                              e.status, e.slot, e.removed, e.hit_total, e.miss_total,
                              e.used, a.status, a.slot, a.removed, a.hit_total,
                              a.miss_total, a.used);
               end
            end
         end
         // request transaction
         if (req_tvalid && req_tready) begin
            e = apply_op(req_tdata);
            expected_q.push_back(e);
            items_seen++;
            if (e.status == lltc_pkg::ST_OK &&
                lltc_pkg::mode_type'(req_tdata[2:0]) == lltc_pkg::MODE_GET)
               hits_seen++;
         end
      end
      pending = expected_q.size();
   end

endmodule

FILE: dv/lfu_lru_ttl_cache_table_top_tb.sv
// ---------------------------------------------------------------------------
// lfu_lru_ttl_cache_table_top_tb: testbench of the cache table
// directed corner operations, then random mixes of put/get/has/remove and
// maintenance operations over several byte budgets, with random stalls on
// both streams and one long response hold-off to back up the request side
// ---------------------------------------------------------------------------
module lfu_lru_ttl_cache_table_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam logic [1:0] ADDR_CAPACITY = 2'd0;

   logic         clock;
   logic         reset;
   logic         req_tvalid, req_tready;
   logic [135:0] req_tdata;   // mode, key_tag, key_bytes, content_bytes, type_bytes,
                              // ttl_seconds, now_ms, target_percent (from bit 0 up)
   logic         rsp_tvalid, rsp_tready;
   logic [95:0]  rsp_tdata;   // status, slot_index, removed_count, hit_total,
                              // miss_total, used_bytes (from bit 0 up)
   logic         csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [1:0]   csr_paddr;
   logic [31:0]  csr_pwdata, csr_prdata;

   int  fail_count, pending, items_seen, hits_seen;
   bit  req_fire;          // request accepted at the last rising edge
   bit  stalls_on;         // random idling on both streams
   bit  hold_rsp;          // asks the response side for one long hold-off
   int  watchdog;
   logic [31:0] clock_ms;  // running time stamp for the requests
   logic [31:0] tag_pool[24];

   always begin
      clock = 1'b1; #6;
      clock = 1'b0; #6;
   end

   lfu_lru_ttl_cache_table_top u_dut (.*);

   lfu_lru_ttl_cache_table_checker u_checker (.*);

   always @(posedge clock) req_fire <= req_tvalid && req_tready;

   // response side: random back-pressure, plus one long stall on request
   initial begin
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp && !hold_done) begin
            hold_done = 1;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else
            rsp_tready <= !(stalls_on && $urandom_range(99) < 6);
      end
   end

   // watchdog: cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         watchdog <= 0;
      else if (watchdog >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d responses outstanding", pending);
         $display("Verification failed");
         $finish;
      end else
         watchdog <= watchdog + 1;
   end

   function automatic logic [135:0] pack_op(lltc_pkg::mode_type op, logic [31:0] tag,
         logic [7:0] kb, logic [15:0] cb, logic [7:0] tb, logic [22:0] ttl,
         logic [31:0] now, logic [7:0] pct);
      return {6'd0, pct, now, ttl, tb, cb, kb, tag, op};
   endfunction

   // one request transaction, returns at the falling edge after acceptance
   task automatic issue(logic [135:0] d);
      while (stalls_on && $urandom_range(99) < 6) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(negedge clock); while (!req_fire);
   endtask

   task automatic issue_op(lltc_pkg::mode_type op, logic [31:0] tag, logic [15:0] cb,
         logic [22:0] ttl, logic [7:0] pct);
      issue(pack_op(op, tag, 8'd16, cb, 8'd10, ttl, clock_ms, pct));
   endtask

   // budget register write, only with nothing in flight
   task automatic set_budget(logic [31:0] v);
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= ADDR_CAPACITY; csr_pwdata <= v;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   // random operation with a bias toward well-formed traffic on a small key set
   task automatic random_op();
      int                 pick;
      lltc_pkg::mode_type op;
      logic [15:0]        cb;
      logic [22:0]        ttl;
      logic [7:0]         kb;
      pick = $urandom_range(99);
      if      (pick < 36) op = lltc_pkg::MODE_PUT;
      else if (pick < 62) op = lltc_pkg::MODE_GET;
      else if (pick < 72) op = lltc_pkg::MODE_HAS;
      else if (pick < 81) op = lltc_pkg::MODE_REMOVE;
      else if (pick < 83) op = lltc_pkg::MODE_CLEAR;
      else if (pick < 90) op = lltc_pkg::MODE_CLEANUP;
      else if (pick < 98) op = lltc_pkg::MODE_OPT;
      else                op = lltc_pkg::MODE_BAD;
      cb  = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(1, 1500));
      kb  = ($urandom_range(29) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      case ($urandom_range(9))
         0, 1:    ttl = '0;
         9:       ttl = 23'($urandom);
         default: ttl = 23'($urandom_range(1, 12));
      endcase
      clock_ms = clock_ms + $urandom_range(0, 2500);
      issue(pack_op(op, tag_pool[$urandom_range(23)], kb, cb, 8'($urandom),
                    ttl, clock_ms, 8'($urandom_range(0, 255))));
   endtask

   initial begin
      int          sizes[5];
      int          counts[5];
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      stalls_on   = 1'b0;
      hold_rsp    = 1'b0;
      clock_ms    = 32'hFFFF_D000;   // time stamps wrap early in the run
      for (int i = 0; i < 24; i++) tag_pool[i] = $urandom;
      tag_pool[0] = 32'h0;
      tag_pool[1] = 32'hFFFF_FFFF;
      repeat (9) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // directed corners at the reset budget
      issue(pack_op(lltc_pkg::MODE_PUT, 32'h1, 8'd0, 16'd5, 8'd0, '0, clock_ms,
                    8'd0));                                                      // no key
      issue(pack_op(lltc_pkg::MODE_PUT, 32'h1, 8'd5, 16'd0, 8'd0, '0, clock_ms,
                    8'd0));                                                      // no content
      issue(pack_op(lltc_pkg::MODE_PUT, 32'h1, 8'hFF, 16'hFFFF, 8'hFF, '1, clock_ms,
                    8'hFF));                                                     // too big
      issue_op(lltc_pkg::MODE_PUT, tag_pool[0], 16'd100, 23'd2, 8'd0);
      issue_op(lltc_pkg::MODE_PUT, tag_pool[1], 16'd200, 23'd0, 8'd0);         // never expires
      issue_op(lltc_pkg::MODE_GET, tag_pool[0], '0, '0, '0);                    // hit
      issue_op(lltc_pkg::MODE_HAS, tag_pool[1], '0, '0, '0);
      issue_op(lltc_pkg::MODE_GET, 32'h1234_5678, '0, '0, '0);                  // miss
      issue_op(lltc_pkg::MODE_PUT, tag_pool[0], 16'd300, 23'd1, 8'd0);         // rewrite
      clock_ms = clock_ms + 32'd1000;                                           // reaches ttl
      issue_op(lltc_pkg::MODE_GET, tag_pool[0], '0, '0, '0);                    // expired
      issue_op(lltc_pkg::MODE_PUT, tag_pool[2], 16'd50, 23'd1, 8'd0);
      clock_ms = clock_ms + 32'd5000;
      issue_op(lltc_pkg::MODE_CLEANUP, '0, '0, '0, '0);
      issue_op(lltc_pkg::MODE_REMOVE, tag_pool[1], '0, '0, '0);
      issue_op(lltc_pkg::MODE_REMOVE, tag_pool[1], '0, '0, '0);                 // gone already
      for (int i = 0; i < 18; i++)                                              // fill and evict
         issue_op(lltc_pkg::MODE_PUT, 32'h100 + i, 16'd1200, 23'd0, 8'd0);
      issue_op(lltc_pkg::MODE_OPT, '0, '0, '0, 8'd10);
      issue_op(lltc_pkg::MODE_OPT, '0, '0, '0, 8'd0);                           // default target
      issue_op(lltc_pkg::MODE_CLEAR, '0, '0, '0, '0);
      issue(pack_op(lltc_pkg::MODE_BAD, '1, '1, '1, '1, '1, '1, '1));

      // random phases over several budgets, the extremes among them
      sizes  = '{16384, 4000, 1048576, 0, 1500};
      counts = '{260, 260, 260, 60, 260};
      for (int p = 0; p < 5; p++) begin
         set_budget(32'(sizes[p]));
         stalls_on = (p != 1);          // one phase runs without idling
         for (int n = 0; n < counts[p]; n++) begin
            if (p == 2 && n == 100) hold_rsp = 1'b1;   // back up the request side
            random_op();
         end
      end
      req_tvalid <= 1'b0;

      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (400) @(negedge clock);
      $display("covered %0d operations (%0d get hits) over five byte budgets,",
               items_seen, hits_seen);
      $display("with random stalls, one long response hold-off and wrapping time stamps");
      if (fail_count == 0 && pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
